FILE: rtl/core/nvfp_pkg.sv
// Shared constants and decode helpers for the NVFP4 dequantizer.
`default_nettype none
package nvfp_pkg;

    localparam logic [31:0] QNAN_BITS  = 32'h7FC0_0000;
    localparam logic [31:0] INF_BITS   = 32'h7F80_0000;
    localparam logic [31:0] ONE_BITS   = 32'h3F80_0000;
    localparam int          FMUL_STAGES = 4;

    // E2M1 magnitudes: 0, 0.5, 1, 1.5, 2, 3, 4, 6
    localparam logic [31:0] E2M1_MAG [8] = '{
        32'h0000_0000, 32'h3F00_0000, 32'h3F80_0000, 32'h3FC0_0000,
        32'h4000_0000, 32'h4040_0000, 32'h4080_0000, 32'h40C0_0000
    };

    function automatic logic [31:0] f_dec_e2m1(input logic [3:0] code);
        logic [31:0] mag;
        mag = E2M1_MAG[code[2:0]];
        return {code[3], mag[30:0]};
    endfunction

    function automatic logic [31:0] f_dec_e4m3(input logic [7:0] b);
        logic [3:0]  ex;
        logic [2:0]  man;
        logic [31:0] res;
        ex  = b[6:3];
        man = b[2:0];
        if (ex == 4'd0) begin
            // subnormal: man * 2^-9
            if (man[2]) begin
                res = {b[7], 8'd120, man[1:0], 21'd0};
            end else if (man[1]) begin
                res = {b[7], 8'd119, man[0], 22'd0};
            end else if (man[0]) begin
                res = {b[7], 8'd118, 23'd0};
            end else begin
                res = {b[7], 31'd0};
            end
        end else if (ex == 4'hF && man == 3'h7) begin
            res = QNAN_BITS;
        end else begin
            res = {b[7], 4'd0, ex, 3'd0, 20'd0} + {1'b0, 8'd120, 23'd0}
                  + {9'd0, man, 20'd0};
        end
        return res;
    endfunction

    // leading zeros of a 24-bit word (input known nonzero where used)
    function automatic logic [4:0] f_lzc24(input logic [23:0] v);
        logic [4:0] n;
        logic       found;
        n     = 5'd0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found && v[i]) begin
                found = 1'b1;
                n     = 5'(23 - i);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/nvfp_fmul.sv
// Four-stage pipelined IEEE binary32 multiplier, round to nearest even.
`default_nettype none
module nvfp_fmul (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [31:0] y
);
    import nvfp_pkg::*;

    typedef struct packed {
        logic sign;
        logic nan;
        logic inf;
        logic zero;
    } flags_t;

    // stage 1: classify, leading-zero count
    flags_t      f1_reg, f1_next;
    logic [7:0]  ea1_reg, eb1_reg;
    logic [22:0] fa1_reg, fb1_reg;
    logic [4:0]  sha1_reg, shb1_reg;

    always_comb begin
        logic za, zb, na, nb;
        za = (a[30:23] == 8'd0) && (a[22:0] == 23'd0);
        zb = (b[30:23] == 8'd0) && (b[22:0] == 23'd0);
        na = (a[30:23] == 8'hFF);
        nb = (b[30:23] == 8'hFF);
        f1_next.sign = a[31] ^ b[31];
        f1_next.nan  = (na && a[22:0] != 23'd0) || (nb && b[22:0] != 23'd0)
                       || ((na || nb) && (za || zb));
        f1_next.inf  = na || nb;
        f1_next.zero = za || zb;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_reg   <= f1_next;
            ea1_reg  <= a[30:23];
            eb1_reg  <= b[30:23];
            fa1_reg  <= a[22:0];
            fb1_reg  <= b[22:0];
            sha1_reg <= f_lzc24({1'b0, a[22:0]});
            shb1_reg <= f_lzc24({1'b0, b[22:0]});
        end
    end

    // stage 2: normalize significands
    flags_t             f2_reg;
    logic [23:0]        ma2_reg, mb2_reg, ma2_next, mb2_next;
    logic signed [9:0]  xa2_reg, xb2_reg, xa2_next, xb2_next;

    always_comb begin
        if (ea1_reg == 8'd0) begin
            ma2_next = {1'b0, fa1_reg} << sha1_reg;
            xa2_next = 10'sd1 - signed'({5'd0, sha1_reg});
        end else begin
            ma2_next = {1'b1, fa1_reg};
            xa2_next = signed'({2'd0, ea1_reg});
        end
        if (eb1_reg == 8'd0) begin
            mb2_next = {1'b0, fb1_reg} << shb1_reg;
            xb2_next = 10'sd1 - signed'({5'd0, shb1_reg});
        end else begin
            mb2_next = {1'b1, fb1_reg};
            xb2_next = signed'({2'd0, eb1_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f2_reg  <= f1_reg;
            ma2_reg <= ma2_next;
            mb2_reg <= mb2_next;
            xa2_reg <= xa2_next;
            xb2_reg <= xb2_next;
        end
    end

    // stage 3: significand product
    flags_t             f3_reg;
    logic [47:0]        p3_reg;
    logic signed [11:0] e3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            f3_reg <= f2_reg;
            p3_reg <= ma2_reg * mb2_reg;
            e3_reg <= 12'(xa2_reg) + 12'(xb2_reg) - 12'sd127;
        end
    end

    // stage 4: round and pack
    logic [31:0] y_reg, y_next;

    always_comb begin
        logic [47:0]        pn;
        logic signed [11:0] en4, extra;
        logic [5:0]         s;
        logic [9:0]         ebias;
        logic [63:0]        q, rem, half;
        logic [33:0]        bits;
        if (p3_reg[47]) begin
            pn  = p3_reg;
            en4 = e3_reg + 12'sd1;
        end else begin
            pn  = {p3_reg[46:0], 1'b0};
            en4 = e3_reg;
        end
        extra = 12'sd25 - en4;
        if (en4 < 12'sd1) begin
            s     = (extra > 12'sd62) ? 6'd62 : extra[5:0];
            ebias = 10'd0;
        end else begin
            s     = 6'd24;
            ebias = 10'(en4 - 12'sd1);
        end
        q    = {16'd0, pn} >> s;
        rem  = {16'd0, pn} & ((64'd1 << s) - 64'd1);
        half = 64'd1 << (s - 6'd1);
        if (rem > half || (rem == half && q[0])) begin
            q = q + 64'd1;
        end
        bits = {1'b0, ebias, 23'd0} + q[33:0];
        if (f3_reg.nan) begin
            y_next = QNAN_BITS;
        end else if (f3_reg.inf) begin
            y_next = {f3_reg.sign, INF_BITS[30:0]};
        end else if (f3_reg.zero) begin
            y_next = {f3_reg.sign, 31'd0};
        end else if (ebias >= 10'd255 || bits >= {2'd0, INF_BITS}) begin
            y_next = {f3_reg.sign, INF_BITS[30:0]};
        end else begin
            y_next = {f3_reg.sign, bits[30:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule
`default_nettype wire

FILE: rtl/core/nvfp_lane.sv
// One dequantization lane: E2M1 decode times the combined scale.
`default_nettype none
module nvfp_lane (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [3:0]  code,
    input  wire logic [31:0] scale,
    output logic      [31:0] value
);
    import nvfp_pkg::*;

    logic [31:0] weight;

    assign weight = f_dec_e2m1(code);

    nvfp_fmul u_fmul (
        .aclk (aclk),
        .en   (en),
        .a    (weight),
        .b    (scale),
        .y    (value)
    );

endmodule
`default_nettype wire

FILE: rtl/core/nvfp4_dequantizer.sv
// Top level: NVFP4 dequantizer, block scale times global scale, two weight lanes.
//
//  channel   dir  ports                                         handshake
//  s_*       in   s_packed_pair, s_block_scale, s_end_of_data   s_valid / s_ready
//  m_*       out  m_even_value, m_odd_value, m_end_of_data_out  m_valid / m_ready
//  cfg       in   global_scale_wdata                            global_scale_we
//
//  One word per cycle while the output is not stalled; the path runs through the
//  4-stage scale multiplier, the 4-stage lane multipliers and the output register.
//  The whole pipeline advances together; it holds only while a result sits
//  in the output register and m_ready is low, so s_ready = !m_valid | m_ready.
//  aresetn (synchronous) clears all valid bits and sets the global scale to 1.0.
`default_nettype none
module nvfp4_dequantizer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        global_scale_we,
    input  wire logic [31:0] global_scale_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_packed_pair,
    input  wire logic [7:0]  s_block_scale,
    input  wire logic        s_end_of_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [31:0] m_even_value,
    output logic      [31:0] m_odd_value,
    output logic             m_end_of_data_out
);
    import nvfp_pkg::*;

    localparam int DEPTH = 2 * FMUL_STAGES;

    logic        adv;
    logic [31:0] gscale_reg;
    logic [31:0] scale_dec;
    logic [31:0] scale_prod;
    logic [31:0] even_res, odd_res;

    // valid and last-marker tracking through the pipeline
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] last_reg;
    // weight byte waits for the scale product
    logic [7:0]       pair_reg [FMUL_STAGES];

    logic        m_valid_reg;
    logic [31:0] even_reg, odd_reg;
    logic        eod_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gscale_reg <= ONE_BITS;
        end else if (global_scale_we) begin
            gscale_reg <= global_scale_wdata;
        end
    end

    assign scale_dec = f_dec_e4m3(s_block_scale);

    // block scale times global scale
    nvfp_fmul u_scale (
        .aclk (aclk),
        .en   (adv),
        .a    (scale_dec),
        .b    (gscale_reg),
        .y    (scale_prod)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            pair_reg[0] <= s_packed_pair;
            for (int i = 1; i < FMUL_STAGES; i++) begin
                pair_reg[i] <= pair_reg[i-1];
            end
            last_reg <= {last_reg[DEPTH-2:0], s_end_of_data};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
        end
    end

    // two lanes share the scale product
    nvfp_lane u_lane_even (
        .aclk  (aclk),
        .en    (adv),
        .code  (pair_reg[FMUL_STAGES-1][3:0]),
        .scale (scale_prod),
        .value (even_res)
    );

    nvfp_lane u_lane_odd (
        .aclk  (aclk),
        .en    (adv),
        .code  (pair_reg[FMUL_STAGES-1][7:4]),
        .scale (scale_prod),
        .value (odd_res)
    );

    // merge: lane results and marker into the output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            even_reg <= even_res;
            odd_reg  <= odd_res;
            eod_reg  <= last_reg[DEPTH-1];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_even_value      = even_reg;
    assign m_odd_value       = odd_reg;
    assign m_end_of_data_out = eod_reg;

endmodule
`default_nettype wire

FILE: rtl/core/nvfp_checker.sv
// Port-level checks for the NVFP4 dequantizer, bound to the top level.
`default_nettype none
module nvfp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_even_value,
    input wire logic [31:0] m_odd_value,
    input wire logic        m_end_of_data_out
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_even_value) && $stable(m_odd_value)
                                && $stable(m_end_of_data_out))
        else $error("result word changed while stalled");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stall");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind nvfp4_dequantizer nvfp_checker u_nvfp_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_even_value      (m_even_value),
    .m_odd_value       (m_odd_value),
    .m_end_of_data_out (m_end_of_data_out)
);
`default_nettype wire
